// ===== hw/rtl/cdq_pkg.sv =====
// shared constants and operation codes for the circular deque
package cdq_pkg;

    localparam int DEFAULT_MAX_DEPTH   = 1024;
    localparam int DEFAULT_VALUE_WIDTH = 32;

    localparam int OP_WIDTH       = 3;
    localparam int CAP_WIDTH      = 11;
    localparam int APB_ADDR_WIDTH = 2;
    localparam int APB_DATA_WIDTH = 32;

    localparam logic [OP_WIDTH-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_QUERY      = 3'd4;

    localparam logic [APB_ADDR_WIDTH-1:0] REG_CAPACITY = 2'd0;

endpackage

// ===== hw/rtl/cdq_ring.sv =====
// ring store: one write port and two registered read ports with write bypass
module cdq_ring #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
    input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
    output logic [WIDTH-1:0]         rd_a_data,
    output logic [WIDTH-1:0]         rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_a_addr)) begin
            rd_a_reg <= wr_data;
        end else begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (wr_en && (wr_addr == rd_b_addr)) begin
            rd_b_reg <= wr_data;
        end else begin
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

// ===== hw/rtl/circular_deque_top.sv =====
// circular deque top level: request channel, result channel and capacity register
// A double-ended queue of signed words in a ring store of MAX_DEPTH entries, of which
// the capacity register (address 0) selects how many are in use; writing it empties
// the queue; only low CAP_WIDTH bits count, 0 acts as 1, larger values as MAX_DEPTH.
// One request is taken every clock cycle while s_ready is high, and its result word
// appears from the output register; a second result register lets one more request
// in while the output is stalled. The front and rear words and their neighbors are
// held in registers, refreshed each cycle from both ring store read ports, so every
// operation finishes in a single pass. The store needs no clearing after reset.
module circular_deque_top #(
    parameter int MAX_DEPTH   = cdq_pkg::DEFAULT_MAX_DEPTH,
    parameter int VALUE_WIDTH = cdq_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cdq_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [cdq_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [cdq_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [cdq_pkg::OP_WIDTH-1:0]        s_op,
    input  logic signed [VALUE_WIDTH-1:0]       s_value,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_accepted,
    output logic signed [VALUE_WIDTH-1:0]       m_front_value,
    output logic signed [VALUE_WIDTH-1:0]       m_rear_value,
    output logic                                m_is_empty,
    output logic                                m_is_full
);

    import cdq_pkg::*;

    localparam int AW = $clog2(MAX_DEPTH);
    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int RW = 2 * VALUE_WIDTH + 3;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx,
                                               input logic [CW-1:0] cap);
        logic [CW-1:0] sum;
        sum = CW'(idx) + CW'(1);
        return (sum >= cap) ? '0 : AW'(sum);
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] idx,
                                               input logic [CW-1:0] cap);
        logic [CW-1:0] top;
        top = cap - CW'(1);
        return (idx == '0) ? AW'(top) : idx - AW'(1);
    endfunction

    // state
    logic [CW-1:0]          cap_reg,   cap_next;
    logic [AW-1:0]          front_reg, front_next;
    logic [AW-1:0]          rear_reg,  rear_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [VALUE_WIDTH-1:0] fval_reg,  fval_next;
    logic [VALUE_WIDTH-1:0] rval_reg,  rval_next;

    // ring store
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_a_addr;
    logic [AW-1:0]          rd_b_addr;
    logic [VALUE_WIDTH-1:0] sec_front;
    logic [VALUE_WIDTH-1:0] sec_rear;

    // output buffer
    logic          m_valid_reg;
    logic          skid_valid_reg;
    logic [RW-1:0] out_data_reg;
    logic [RW-1:0] skid_data_reg;
    logic [RW-1:0] res_word;

    logic                   s_fire;
    logic                   cfg_we;
    logic [CAP_WIDTH-1:0]   cap_raw;
    logic [CW-1:0]          cap_wr;
    logic                   cur_empty;
    logic                   cur_full;
    logic                   res_accepted;
    logic                   res_empty;
    logic                   res_full;
    logic [VALUE_WIDTH-1:0] res_front;
    logic [VALUE_WIDTH-1:0] res_rear;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && (paddr == REG_CAPACITY);
    assign prdata  = (paddr == REG_CAPACITY) ? APB_DATA_WIDTH'(cap_reg) : '0;
    assign cap_raw = pwdata[CAP_WIDTH-1:0];

    always_comb begin
        if (cap_raw == '0) begin
            cap_wr = CW'(1);
        end else if (32'(cap_raw) > 32'(MAX_DEPTH)) begin
            cap_wr = CW'(MAX_DEPTH);
        end else begin
            cap_wr = CW'(cap_raw);
        end
    end

    assign s_ready   = aresetn && !skid_valid_reg;
    assign s_fire    = s_valid && s_ready;
    assign cur_empty = (count_reg == '0);
    assign cur_full  = (count_reg >= cap_reg);

    // one request against the current state, overridden by a capacity write
    always_comb begin
        cap_next     = cap_reg;
        front_next   = front_reg;
        rear_next    = rear_reg;
        count_next   = count_reg;
        fval_next    = fval_reg;
        rval_next    = rval_reg;
        wr_en        = 1'b0;
        wr_addr      = front_reg;
        res_accepted = 1'b1;
        case (s_op)
            OP_PUSH_FRONT: begin
                if (cur_full) begin
                    res_accepted = 1'b0;
                end else begin
                    front_next = wrap_dec(front_reg, cap_reg);
                    count_next = count_reg + CW'(1);
                    wr_en      = s_fire;
                    wr_addr    = front_next;
                    fval_next  = s_value;
                    if (cur_empty) begin
                        rval_next = s_value;
                    end
                end
            end
            OP_PUSH_BACK: begin
                if (cur_full) begin
                    res_accepted = 1'b0;
                end else begin
                    rear_next  = wrap_inc(rear_reg, cap_reg);
                    count_next = count_reg + CW'(1);
                    wr_en      = s_fire;
                    wr_addr    = rear_next;
                    rval_next  = s_value;
                    if (cur_empty) begin
                        fval_next = s_value;
                    end
                end
            end
            OP_POP_FRONT: begin
                if (cur_empty) begin
                    res_accepted = 1'b0;
                end else begin
                    front_next = wrap_inc(front_reg, cap_reg);
                    count_next = count_reg - CW'(1);
                    fval_next  = sec_front;
                end
            end
            OP_POP_BACK: begin
                if (cur_empty) begin
                    res_accepted = 1'b0;
                end else begin
                    rear_next  = wrap_dec(rear_reg, cap_reg);
                    count_next = count_reg - CW'(1);
                    rval_next  = sec_rear;
                end
            end
            OP_QUERY: begin
            end
            default: begin
            end
        endcase
        if (!s_fire) begin
            front_next = front_reg;
            rear_next  = rear_reg;
            count_next = count_reg;
            fval_next  = fval_reg;
            rval_next  = rval_reg;
        end
        if (cfg_we) begin
            cap_next   = cap_wr;
            front_next = '0;
            rear_next  = wrap_dec('0, cap_wr);
            count_next = '0;
        end
    end

    assign res_empty = (count_next == '0);
    assign res_full  = (count_next >= cap_reg);
    assign res_front = res_empty ? '1 : fval_next;
    assign res_rear  = res_empty ? '1 : rval_next;
    assign res_word  = {res_accepted, res_front, res_rear, res_empty, res_full};

    // neighbors of the front and rear words for the next request
    assign rd_a_addr = wrap_inc(front_next, cap_next);
    assign rd_b_addr = wrap_dec(rear_next, cap_next);

    cdq_ring #(
        .DEPTH (MAX_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_ring (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (s_value),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (sec_front),
        .rd_b_data (sec_rear)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CW'(MAX_DEPTH);
            front_reg <= '0;
            rear_reg  <= AW'(MAX_DEPTH - 1);
            count_reg <= '0;
        end else begin
            cap_reg   <= cap_next;
            front_reg <= front_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        fval_reg <= fval_next;
        rval_reg <= rval_next;
    end

    // output register plus skid word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= s_fire;
            end
        end else if (s_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (s_fire) begin
                out_data_reg <= res_word;
            end
        end else if (s_fire) begin
            skid_data_reg <= res_word;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_accepted    = out_data_reg[RW-1];
    assign m_front_value = out_data_reg[RW-2 -: VALUE_WIDTH];
    assign m_rear_value  = out_data_reg[VALUE_WIDTH+1 -: VALUE_WIDTH];
    assign m_is_empty    = out_data_reg[1];
    assign m_is_full     = out_data_reg[0];

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_reg)
        else $error("entry count above capacity");

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid word held without output word");

    a_empty_reads_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_empty) |-> ((&m_front_value) && (&m_rear_value)))
        else $error("empty result without all-ones values");

    a_push_back_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !cfg_we && (s_op == OP_PUSH_BACK) && !cur_full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push back did not grow the queue");
`endif

endmodule

// ===== tb/tb.sv =====
// testbench for the circular deque: directed and random requests checked against a deque predictor
module tb;
    import cdq_pkg::*;

    localparam int DEPTH         = DEFAULT_MAX_DEPTH;
    localparam int VW            = DEFAULT_VALUE_WIDTH;
    localparam int RING_AW       = $clog2(DEPTH);
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PRINT_LIMIT   = 50;

    localparam logic [OP_WIDTH-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [OP_WIDTH-1:0] OP_RESERVED_LAST  = 3'd7;

    typedef logic [OP_WIDTH-1:0] op_t;
    typedef logic signed [VW-1:0] word_t;

    typedef struct packed {
        logic  accepted;
        word_t front_value;
        word_t rear_value;
        logic  is_empty;
        logic  is_full;
    } deque_result_t;

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      psel     = 1'b0;
    logic                      penable  = 1'b0;
    logic                      pwrite   = 1'b0;
    logic [APB_ADDR_WIDTH-1:0] paddr    = '0;
    logic [APB_DATA_WIDTH-1:0] pwdata   = '0;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;
    logic                      s_valid  = 1'b0;
    logic                      s_ready;
    op_t                       s_op     = OP_QUERY;
    word_t                     s_value  = '0;
    logic                      m_valid;
    logic                      m_ready  = 1'b0;
    logic                      m_accepted;
    word_t                     m_front_value;
    word_t                     m_rear_value;
    logic                      m_is_empty;
    logic                      m_is_full;

    word_t         ring [DEPTH];
    int unsigned   head_idx    = 0;
    int unsigned   fill_count  = 0;
    int unsigned   cap_entries = DEPTH;
    deque_result_t expected_results [$];

    int error_count      = 0;
    int cycle_count      = 0;
    bit sender_idle_on   = 1'b1;
    bit sink_stall_on    = 1'b1;
    int sink_hold_cycles = 0;

    circular_deque_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_accepted    (m_accepted),
        .m_front_value (m_front_value),
        .m_rear_value  (m_rear_value),
        .m_is_empty    (m_is_empty),
        .m_is_full     (m_is_full)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned ring_slot(input int unsigned offset);
        int unsigned idx;
        idx = head_idx + offset;
        if (idx >= cap_entries)
            idx -= cap_entries;
        return idx;
    endfunction

    function automatic deque_result_t step_deque(input op_t op, input word_t value);
        deque_result_t res;
        bit            full_now;
        bit            empty_now;
        int unsigned   slot;
        full_now     = fill_count >= cap_entries;
        empty_now    = fill_count == 0;
        res.accepted = 1'b1;
        case (op)
            OP_PUSH_FRONT: begin
                if (full_now) begin
                    res.accepted = 1'b0;
                end else begin
                    slot       = (head_idx == 0) ? cap_entries - 1 : head_idx - 1;
                    ring[RING_AW'(slot)] = value;
                    head_idx   = slot;
                    fill_count++;
                end
            end
            OP_PUSH_BACK: begin
                if (full_now) begin
                    res.accepted = 1'b0;
                end else begin
                    slot       = ring_slot(fill_count);
                    ring[RING_AW'(slot)] = value;
                    fill_count++;
                end
            end
            OP_POP_FRONT: begin
                if (empty_now) begin
                    res.accepted = 1'b0;
                end else begin
                    head_idx = ring_slot(1);
                    fill_count--;
                end
            end
            OP_POP_BACK: begin
                if (empty_now)
                    res.accepted = 1'b0;
                else
                    fill_count--;
            end
            default: ;
        endcase
        res.is_empty = fill_count == 0;
        res.is_full  = fill_count >= cap_entries;
        if (res.is_empty) begin
            res.front_value = '1;
            res.rear_value  = '1;
        end else begin
            res.front_value = ring[RING_AW'(head_idx)];
            res.rear_value  = ring[RING_AW'(ring_slot(fill_count - 1))];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [VW-1:0] got,
                                   input logic [VW-1:0] want);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge aclk) begin
        deque_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("word with nothing expected", m_front_value, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_accepted !== want.accepted)
                    report_mismatch("accepted", VW'(m_accepted), VW'(want.accepted));
                if (m_front_value !== want.front_value)
                    report_mismatch("front_value", m_front_value, want.front_value);
                if (m_rear_value !== want.rear_value)
                    report_mismatch("rear_value", m_rear_value, want.rear_value);
                if (m_is_empty !== want.is_empty)
                    report_mismatch("is_empty", VW'(m_is_empty), VW'(want.is_empty));
                if (m_is_full !== want.is_full)
                    report_mismatch("is_full", VW'(m_is_full), VW'(want.is_full));
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (sink_hold_cycles > 0) begin
            m_ready <= 1'b0;
            sink_hold_cycles--;
        end else if (sink_stall_on && $urandom_range(99) < 17) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_request(input op_t op, input word_t value);
        if (sender_idle_on && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_value <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
        expected_results.push_back(step_deque(op, value));
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [APB_DATA_WIDTH-1:0] raw);
        int unsigned cap;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CAPACITY;
        pwdata  <= raw;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap = 32'(raw[CAP_WIDTH-1:0]);
        if (cap < 1)
            cap = 1;
        if (cap > DEPTH)
            cap = DEPTH;
        cap_entries = cap;
        head_idx    = 0;
        fill_count  = 0;
    endtask

    function automatic word_t pick_value();
        if ($urandom_range(99) < 10) begin
            case ($urandom_range(3))
                0: return {1'b1, {(VW-1){1'b0}}};
                1: return {1'b0, {(VW-1){1'b1}}};
                2: return '1;
                default: return '0;
            endcase
        end
        return word_t'($urandom());
    endfunction

    function automatic op_t pick_op(input bit filling);
        int unsigned r;
        op_t         push_op;
        op_t         pop_op;
        r       = $urandom_range(99);
        push_op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        pop_op  = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
        if (r < 4)
            return op_t'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
        if (r < 10)
            return OP_QUERY;
        if (r < 70)
            return filling ? push_op : pop_op;
        return filling ? pop_op : push_op;
    endfunction

    // fill toward full, then drain toward empty, with random turns in between
    task automatic run_random(input int count);
        bit filling;
        filling = 1'b1;
        repeat (count) begin
            if (fill_count >= cap_entries)
                filling = 1'b0;
            else if (fill_count == 0)
                filling = 1'b1;
            else if ($urandom_range(99) < 3)
                filling = !filling;
            send_request(pick_op(filling), pick_value());
        end
    endtask

    task automatic test_reset_state();
        send_request(OP_QUERY, '0);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_POP_BACK, '1);
        send_request(OP_RESERVED_FIRST, '0);
        send_request(OP_RESERVED_LAST, '1);
        send_request(OP_PUSH_FRONT, {1'b1, {(VW-1){1'b0}}});
        send_request(OP_PUSH_BACK, {1'b0, {(VW-1){1'b1}}});
        send_request(OP_QUERY, '0);
        send_request(OP_POP_BACK, '0);
        send_request(OP_POP_FRONT, '0);
    endtask

    task automatic test_capacity_edges();
        write_capacity('0);
        send_request(OP_PUSH_BACK, '1);
        send_request(OP_PUSH_FRONT, 32'h1234_5678);
        send_request(OP_QUERY, '0);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_POP_BACK, '0);
        write_capacity(32'd2);
        send_request(OP_PUSH_FRONT, '0);
        send_request(OP_PUSH_FRONT, 32'h5555_5555);
        send_request(OP_PUSH_BACK, 32'h0F0F_0F0F);
        send_request(OP_POP_BACK, '0);
        send_request(OP_PUSH_BACK, 32'hAAAA_AAAA);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_RESERVED_LAST, '0);
    endtask

    task automatic test_deep_fill();
        write_capacity(32'd2047);
        repeat (64) send_request($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                                 pick_value());
        send_request(OP_PUSH_BACK, pick_value());
        send_request(OP_PUSH_FRONT, pick_value());
        repeat (16) send_request($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, '0);
        repeat (16) send_request($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                                 pick_value());
        send_request(OP_QUERY, '0);
    endtask

    task automatic test_random_capacities();
        logic [APB_DATA_WIDTH-1:0] caps [7];
        caps    = '{32'd1, 32'd2, 32'hFFFF_F803, 32'd7, DEPTH, 32'd64, 32'd5};
        caps[6] = $urandom_range(4, 40);
        foreach (caps[i]) begin
            write_capacity(caps[i]);
            run_random(caps[i] == 32'd64 ? 90 : 50);
        end
    endtask

    task automatic test_output_hold();
        write_capacity(32'd6);
        sink_hold_cycles = 80;
        run_random(30);
        wait_for_results();
        run_random(30);
    endtask

    task automatic test_quiet_stretch();
        write_capacity($urandom_range(3, 12));
        sender_idle_on = 1'b0;
        sink_stall_on  = 1'b0;
        run_random(150);
        sender_idle_on = 1'b1;
        sink_stall_on  = 1'b1;
        run_random(40);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_capacity_edges();
        test_deep_fill();
        test_random_capacities();
        test_output_hold();
        test_quiet_stretch();
        wait_for_results();
        repeat (SETTLE_CYCLES * 4) @(posedge aclk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
